>>> hw/rtl/npd_pkg.sv
// Needle position debouncer package: item types, state codes, register map.
// No dependencies; used by the interfaces, the top level and the checker.
package npd_pkg;

  typedef struct packed {
    logic        top_sensor;
    logic        bottom_sensor;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [3:0] status_code;
    logic       needle_up;
    logic       needle_down;
    logic       last_position;
  } out_item_t;

  localparam int unsigned StateW = 4;
  localparam int unsigned StampW = 32;
  localparam int unsigned DelayW = 16;
  localparam int unsigned PaddrW = 3;
  localparam int unsigned PdataW = 32;

  localparam logic [StateW-1:0] ST_UNK_ARMED  = 4'd0;
  localparam logic [StateW-1:0] ST_UNK_WAIT   = 4'd1;
  localparam logic [StateW-1:0] ST_UNK_TRIG   = 4'd2;
  localparam logic [StateW-1:0] ST_UNK_HOLD   = 4'd3;
  localparam logic [StateW-1:0] ST_TOP_ARMED  = 4'd4;
  localparam logic [StateW-1:0] ST_TOP_WAIT   = 4'd5;
  localparam logic [StateW-1:0] ST_TOP_TRIG   = 4'd6;
  localparam logic [StateW-1:0] ST_TOPH_ARMED = 4'd7;
  localparam logic [StateW-1:0] ST_TOPH_WAIT  = 4'd8;
  localparam logic [StateW-1:0] ST_TOP_HOLD   = 4'd9;
  localparam logic [StateW-1:0] ST_BOT_ARMED  = 4'd10;
  localparam logic [StateW-1:0] ST_BOT_WAIT   = 4'd11;
  localparam logic [StateW-1:0] ST_BOT_TRIG   = 4'd12;
  localparam logic [StateW-1:0] ST_BOT_HOLD   = 4'd13;

  localparam logic POS_TOP    = 1'b0;
  localparam logic POS_BOTTOM = 1'b1;

  // register select is paddr[2]
  localparam logic REG_BOUNCE_DELAY   = 1'b0;
  localparam logic REG_TOP_HOLD_DELAY = 1'b1;

  localparam logic [DelayW-1:0] BOUNCE_DELAY_RST   = 16'd5;
  localparam logic [DelayW-1:0] TOP_HOLD_DELAY_RST = 16'd100;

endpackage

>>> hw/rtl/npd_in_if.sv
// Sensor poll channel: valid/ready handshake carrying one in_item_t.
// Depends on npd_pkg.
interface npd_in_if import npd_pkg::*;;
  logic     valid;
  logic     ready;
  in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

>>> hw/rtl/npd_out_if.sv
// Status channel: valid/ready handshake carrying one out_item_t.
// Depends on npd_pkg.
interface npd_out_if import npd_pkg::*;;
  logic      valid;
  logic      ready;
  out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

>>> hw/rtl/needle_position_debouncer_top.sv
// Needle position debouncer top level: input register, qualifier, result register.
// Depends on npd_pkg, npd_in_if, npd_out_if.

// One sensor poll item is accepted per cycle and its status item passes through
// the input register, then the result register; sustained rate is one item per
// cycle while the result register is taken, limited by the single qualifier
// update step (a 4-bit state, one 32-bit timestamp subtract and a compare
// against the selected delay). A full result register that is not taken stalls
// the input register, which in turn drops in_i.ready. Delay registers sit on an
// APB port at byte addresses 0 (bounce delay) and 4 (top hold delay) and should
// be written only while no items are in flight.
module needle_position_debouncer_top import npd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  npd_in_if.sink            in_i,
  npd_out_if.source         out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready
);

  logic [DelayW-1:0] bounce_q, hold_q;
  logic              cfg_wr;

  logic              in_vld_q;
  in_item_t          in_q;
  logic              s2_fire;

  logic [StateW-1:0] state_q, state_d;
  logic [StampW-1:0] stamp_q;
  logic              stamp_ld;
  logic              pos_q, pos_d;
  logic [StampW-1:0] delta;
  logic              bounce_done, hold_done;

  logic              out_vld_q;
  out_item_t         out_q;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = (paddr[2] == REG_TOP_HOLD_DELAY) ?
                  {{(PdataW-DelayW){1'b0}}, hold_q} :
                  {{(PdataW-DelayW){1'b0}}, bounce_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bounce_q <= BOUNCE_DELAY_RST;
      hold_q   <= TOP_HOLD_DELAY_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_BOUNCE_DELAY) begin
        bounce_q <= pwdata[DelayW-1:0];
      end else begin
        hold_q <= pwdata[DelayW-1:0];
      end
    end
  end

  // handshake
  assign s2_fire    = in_vld_q & (~out_vld_q | out_o.ready);
  assign in_i.ready = ~in_vld_q | s2_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_q <= in_i.item;
    end
  end

  // qualifier
  assign delta       = in_q.now_ms - stamp_q;
  assign bounce_done = delta > {{(StampW-DelayW){1'b0}}, bounce_q};
  assign hold_done   = delta > {{(StampW-DelayW){1'b0}}, hold_q};

  always_comb begin
    state_d  = state_q;
    stamp_ld = 1'b0;
    pos_d    = pos_q;
    unique case (state_q)
      ST_UNK_ARMED: begin
        if (in_q.top_sensor) state_d = ST_TOP_ARMED;
        else if (in_q.bottom_sensor) state_d = ST_BOT_ARMED;
        else begin
          stamp_ld = 1'b1;
          state_d  = ST_UNK_WAIT;
        end
      end
      ST_UNK_WAIT: begin
        if (in_q.top_sensor) state_d = ST_TOP_ARMED;
        else if (in_q.bottom_sensor) state_d = ST_BOT_ARMED;
        else if (bounce_done) state_d = ST_UNK_TRIG;
      end
      ST_UNK_TRIG: begin
        if (in_q.top_sensor) state_d = ST_TOP_ARMED;
        else if (in_q.bottom_sensor) state_d = ST_BOT_ARMED;
        else state_d = ST_UNK_HOLD;
      end
      ST_UNK_HOLD: begin
        if (in_q.top_sensor) state_d = ST_TOP_ARMED;
        else if (in_q.bottom_sensor) state_d = ST_BOT_ARMED;
      end
      ST_TOP_ARMED: begin
        if (in_q.top_sensor) begin
          stamp_ld = 1'b1;
          state_d  = ST_TOP_WAIT;
        end else if (in_q.bottom_sensor) state_d = ST_BOT_ARMED;
        else state_d = ST_UNK_ARMED;
      end
      ST_TOP_WAIT: begin
        if (in_q.top_sensor) begin
          if (bounce_done) state_d = ST_TOP_TRIG;
        end else if (in_q.bottom_sensor) state_d = ST_BOT_ARMED;
        else state_d = ST_UNK_ARMED;
      end
      ST_TOP_TRIG: begin
        pos_d = POS_TOP;
        if (in_q.top_sensor) state_d = ST_TOPH_ARMED;
        else if (in_q.bottom_sensor) state_d = ST_BOT_ARMED;
        else state_d = ST_UNK_ARMED;
      end
      ST_TOPH_ARMED: begin
        stamp_ld = 1'b1;
        state_d  = ST_TOPH_WAIT;
      end
      ST_TOPH_WAIT: begin
        if (hold_done) state_d = ST_TOP_HOLD;
      end
      ST_TOP_HOLD: begin
        if (in_q.bottom_sensor) state_d = ST_BOT_ARMED;
        else if (!in_q.top_sensor) state_d = ST_UNK_ARMED;
      end
      ST_BOT_ARMED: begin
        if (in_q.top_sensor) state_d = ST_TOP_ARMED;
        else if (in_q.bottom_sensor) begin
          stamp_ld = 1'b1;
          state_d  = ST_BOT_WAIT;
        end else state_d = ST_UNK_ARMED;
      end
      ST_BOT_WAIT: begin
        if (in_q.top_sensor) state_d = ST_TOP_ARMED;
        else if (in_q.bottom_sensor) begin
          if (bounce_done) state_d = ST_BOT_TRIG;
        end else state_d = ST_UNK_ARMED;
      end
      ST_BOT_TRIG: begin
        // bottom checked first here
        pos_d = POS_BOTTOM;
        if (in_q.bottom_sensor) state_d = ST_BOT_HOLD;
        else if (in_q.top_sensor) state_d = ST_TOP_ARMED;
        else state_d = ST_UNK_ARMED;
      end
      ST_BOT_HOLD: begin
        if (in_q.top_sensor) state_d = ST_TOP_ARMED;
        else if (!in_q.bottom_sensor) state_d = ST_UNK_ARMED;
      end
      default: state_d = ST_UNK_HOLD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_UNK_HOLD;
      stamp_q <= '0;
      pos_q   <= POS_TOP;
    end else if (s2_fire) begin
      state_q <= state_d;
      pos_q   <= pos_d;
      if (stamp_ld) begin
        stamp_q <= in_q.now_ms;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s2_fire) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_fire) begin
      out_q.status_code   <= state_d;
      out_q.needle_up     <= (state_d == ST_TOP_HOLD);
      out_q.needle_down   <= (state_d == ST_BOT_TRIG) || (state_d == ST_BOT_HOLD);
      out_q.last_position <= pos_d;
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.item  = out_q;

endmodule

>>> hw/rtl/npd_checker.sv
// Port-level checker for the needle position debouncer, bound to the top level.
// Depends on npd_pkg and needle_position_debouncer_top.
module npd_checker import npd_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input out_item_t  out_item_i,
  input logic       pready_i
);

  a_up_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_item_i.needle_up == (out_item_i.status_code == ST_TOP_HOLD)))
    else $error("needle_up disagrees with status");

  a_down_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_item_i.needle_down ==
      ((out_item_i.status_code == ST_BOT_TRIG) || (out_item_i.status_code == ST_BOT_HOLD))))
    else $error("needle_down disagrees with status");

  // position is latched on leaving bottom triggered, so only bottom hold implies it
  a_down_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (out_item_i.status_code == ST_BOT_HOLD)) |->
      (out_item_i.last_position == POS_BOTTOM))
    else $error("bottom hold without bottom position");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_item_i)))
    else $error("stalled item changed");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready_i)
    else $error("pready low");

endmodule

bind needle_position_debouncer_top npd_checker u_npd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_item_i  (out_o.item),
  .pready_i    (pready)
);
